// ===== sv/gha_pkg.sv =====
// gha_pkg: operation and status codes for the generational handle allocator
// no dependencies
`default_nettype none

package gha_pkg;

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FUNC_CREATE  = 2'd0;
  localparam func_t FUNC_DESTROY = 2'd1;
  localparam func_t FUNC_QUERY   = 2'd2;
  localparam func_t FUNC_CLEAR   = 2'd3;

  localparam status_t STAT_DONE    = 2'd0;
  localparam status_t STAT_FULL    = 2'd1;
  localparam status_t STAT_IGNORED = 2'd2;

endpackage

`default_nettype wire

// ===== sv/gha_in_if.sv =====
// gha_in_if: request channel of the handle allocator, valid/ready plus payload
// depends on gha_pkg
`default_nettype none

interface gha_in_if
  import gha_pkg::*;
#(
  parameter int IDX_W = 10,
  parameter int GEN_W = 16
);
  logic             valid;
  logic             ready;
  func_t            func;
  logic [IDX_W-1:0] entity_index;
  logic [GEN_W-1:0] entity_generation;

  modport source (output valid, func, entity_index, entity_generation, input ready);
  modport sink   (input valid, func, entity_index, entity_generation, output ready);
endinterface

`default_nettype wire

// ===== sv/gha_out_if.sv =====
// gha_out_if: result channel of the handle allocator, valid/ready plus payload
// depends on gha_pkg
`default_nettype none

interface gha_out_if
  import gha_pkg::*;
#(
  parameter int IDX_W = 10,
  parameter int GEN_W = 16,
  parameter int CNT_W = 11
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] new_index;
  logic [GEN_W-1:0] new_generation;
  logic             is_live;
  status_t          status;
  logic [CNT_W-1:0] live_count;

  modport source (output valid, new_index, new_generation, is_live, status, live_count,
                  input ready);
  modport sink   (input valid, new_index, new_generation, is_live, status, live_count,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/generational_handle_allocator_unit.sv =====
// generational_handle_allocator_unit: handle allocator with per-slot generation
// memory and a fifo free list of released indices
// depends on gha_pkg, gha_in_if, gha_out_if
//
// sequencing: an item goes from idle to exec, or from idle through look to exec for a
//   create that reuses a freed index (free list read, then generation read); the
//   generation memory's single registered read port sets these steps; a result still
//   waiting downstream holds the next one back for as long as it waits
// the block takes no new item until the result of the last one is loaded; the
//   next item is taken the cycle after the result is loaded, even while that result
//   still waits downstream
// reset: counters, fifo pointers and handshake state clear at once; the generation
//   and free list memories are not cleared and need no clearing pass
`default_nettype none

module generational_handle_allocator_unit
  import gha_pkg::*;
#(
  parameter int MAX_SLOTS = 1024,
  parameter int GEN_BITS  = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  gha_in_if.sink     in_ch,
  gha_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] S_LOOK = 2'd1;  // free list head known, read its generation
  localparam logic [1:0] S_EXEC = 2'd2;  // generation in hand, update and answer

  localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(MAX_SLOTS);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    ring_next = (p == IDX_W'(MAX_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // memories: generation per slot and the ring of freed indices
  logic [GEN_BITS-1:0] gen_mem [MAX_SLOTS];
  logic [IDX_W-1:0]    q_mem   [MAX_SLOTS];

  logic [1:0]          state_r, state_nxt;
  func_t               op_r, op_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [GEN_BITS-1:0] hgen_r, hgen_nxt;   // generation carried by the handle
  logic [IDX_W-1:0]    slot_r, slot_nxt;   // slot whose generation is being read

  logic [CNT_W-1:0]    slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0]    free_count_r, free_count_nxt;
  logic [IDX_W-1:0]    free_head_r, free_head_nxt;
  logic [IDX_W-1:0]    free_tail_r, free_tail_nxt;

  // generation memory port
  logic                gen_re, gen_we;
  logic [IDX_W-1:0]    gen_ra, gen_wa;
  logic [GEN_BITS-1:0] gen_wd, gen_rd_r;

  // free list memory port
  logic                q_re, q_we;
  logic [IDX_W-1:0]    q_rd_r;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    o_idx_r, o_idx_nxt;
  logic [GEN_BITS-1:0] o_gen_r, o_gen_nxt;
  logic                o_live_r, o_live_nxt;
  status_t             o_stat_r, o_stat_nxt;
  logic [CNT_W-1:0]    o_cnt_r, o_cnt_nxt;

  // shared increment and compare unit
  logic [GEN_BITS-1:0] gen_inc;
  logic                handle_live;
  logic                can_load;

  assign gen_inc     = gen_rd_r + 1'b1;
  assign handle_live = (CNT_W'(idx_r) < slots_used_r) && (gen_rd_r == hgen_r) && gen_rd_r[0];
  assign can_load    = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    hgen_nxt       = hgen_r;
    slot_nxt       = slot_r;
    slots_used_nxt = slots_used_r;
    free_count_nxt = free_count_r;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    gen_re         = 1'b0;
    gen_ra         = idx_r;
    gen_we         = 1'b0;
    gen_wa         = slot_r;
    gen_wd         = gen_inc;
    q_re           = 1'b0;
    q_we           = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_idx_nxt      = o_idx_r;
    o_gen_nxt      = o_gen_r;
    o_live_nxt     = o_live_r;
    o_stat_nxt     = o_stat_r;
    o_cnt_nxt      = o_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.func;
          idx_nxt  = in_ch.entity_index;
          hgen_nxt = in_ch.entity_generation;
          slot_nxt = in_ch.entity_index;
          gen_re   = 1'b1;
          gen_ra   = in_ch.entity_index;
          q_re     = 1'b1;
          // reuse of a freed slot needs the queue head before its generation
          state_nxt = (in_ch.func == FUNC_CREATE && free_count_r != '0) ? S_LOOK : S_EXEC;
        end
      end
      S_LOOK: begin
        gen_re    = 1'b1;
        gen_ra    = q_rd_r;
        slot_nxt  = q_rd_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (can_load) begin
          o_idx_nxt  = '0;
          o_gen_nxt  = '0;
          o_live_nxt = 1'b0;
          o_stat_nxt = STAT_DONE;
          unique case (op_r)
            FUNC_CREATE: begin
              if (free_count_r != '0) begin
                gen_we         = 1'b1;
                free_head_nxt  = ring_next(free_head_r);
                free_count_nxt = free_count_r - 1'b1;
                o_idx_nxt      = slot_r;
                o_gen_nxt      = gen_inc;
              end else if (slots_used_r < SLOTS_MAX) begin
                // fresh slot is written with generation 1 and handed out as 1
                gen_we         = 1'b1;
                gen_wa         = slots_used_r[IDX_W-1:0];
                gen_wd         = GEN_BITS'(1);
                slots_used_nxt = slots_used_r + 1'b1;
                o_idx_nxt      = slots_used_r[IDX_W-1:0];
                o_gen_nxt      = GEN_BITS'(1);
              end else begin
                o_stat_nxt = STAT_FULL;
              end
            end
            FUNC_DESTROY: begin
              if (handle_live) begin
                gen_we         = 1'b1;
                gen_wa         = idx_r;
                q_we           = 1'b1;
                free_tail_nxt  = ring_next(free_tail_r);
                free_count_nxt = free_count_r + 1'b1;
              end else begin
                o_stat_nxt = STAT_IGNORED;
              end
            end
            FUNC_QUERY: begin
              o_live_nxt = handle_live;
            end
            FUNC_CLEAR: begin
              slots_used_nxt = '0;
              free_count_nxt = '0;
              free_head_nxt  = '0;
              free_tail_nxt  = '0;
            end
            default: begin
              o_stat_nxt = STAT_DONE;
            end
          endcase
          o_cnt_nxt     = slots_used_nxt - free_count_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slots_used_r <= '0;
      free_count_r <= '0;
      free_head_r  <= '0;
      free_tail_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      free_count_r <= free_count_nxt;
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    hgen_r   <= hgen_nxt;
    slot_r   <= slot_nxt;
    o_idx_r  <= o_idx_nxt;
    o_gen_r  <= o_gen_nxt;
    o_live_r <= o_live_nxt;
    o_stat_r <= o_stat_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  // generation memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (gen_re) begin
      gen_rd_r <= gen_mem[gen_ra];
    end
  end

  // free list ring, written at the tail and read at the head
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[free_tail_r] <= idx_r;
    end
    if (q_re) begin
      q_rd_r <= q_mem[free_head_r];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.new_index      = o_idx_r;
  assign out_ch.new_generation = o_gen_r;
  assign out_ch.is_live        = o_live_r;
  assign out_ch.status         = o_stat_r;
  assign out_ch.live_count     = o_cnt_r;

  // freed slots waiting can never outnumber slots ever used
  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= slots_used_r)
    else $error("free count exceeds slots used");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accept");

  // a failed create hands out nothing
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_stat_r == STAT_FULL) |-> (o_idx_r == '0 && o_gen_r == '0))
    else $error("full create returned a handle");

  // a handed out generation is always odd
  a_odd_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_gen_r != '0) |-> o_gen_r[0])
    else $error("even generation handed out");

  // no result is loaded while one still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(o_cnt_r) && $stable(o_stat_r))
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
